/* design/lpmr_pkg.sv */
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared constants, types and helpers for the length-prefixed mailbox ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

    localparam int NUM_MAILBOXES = 8;
    localparam int RING_BYTES    = 256;

    localparam int OP_W       = 2;
    localparam int MB_W       = 3;
    localparam int LEN_W      = 8;
    localparam int LEN1_W     = LEN_W + 1;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 9;

    localparam int MB_IDX_W   = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
    localparam int PTR_W      = $clog2(RING_BYTES);
    localparam int PTR1_W     = PTR_W + 1;
    localparam int CNT_W      = $clog2(RING_BYTES + 1);
    localparam int ADDR_W     = MB_IDX_W + PTR_W;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int SUM_W      = ((PTR_W > LEN1_W) ? PTR_W : LEN1_W) + 1;
    localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef enum logic [OP_W-1:0] {
        OP_SEND_BEGIN = 2'd0,
        OP_SEND_BYTE  = 2'd1,
        OP_RECV       = 2'd2,
        OP_QUERY      = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_NO_MSG   = 2'd2,
        STAT_SEQ      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WAIT_LEN,
        ST_WAIT_DATA
    } t_state;

    typedef struct packed {
        logic load;
        logic decide;
        logic len_take;
        logic data_take;
    } t_dp_cmd;

    typedef struct packed {
        logic need_len;
        logic need_data;
    } t_dp_stat;

    // base + step, folded once into the ring; step never exceeds RING_BYTES
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [PTR_W-1:0]  base,
                                                   input logic [LEN1_W-1:0] step);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(step);
        if (sum >= SUM_W'(RING_BYTES)) begin
            sum = sum - SUM_W'(RING_BYTES);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] free_space(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] tail,
                                                    input logic [CNT_W-1:0] cnt);
        logic [PTR1_W-1:0] diff;
        if (head == tail && cnt != '0) begin
            diff = '0;
        end else if (tail > head) begin
            diff = PTR1_W'(tail) - PTR1_W'(head);
        end else begin
            diff = PTR1_W'(tail) + PTR1_W'(RING_BYTES) - PTR1_W'(head);
        end
        return CNT_W'(diff);
    endfunction

endpackage

/* design/lpmr_ctrl.sv */
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Sequencer: accepts a command, then steps the datapath through its decision
// and any ring reads that a receive needs.
// ----------------------------------------------------------------------------
module lpmr_ctrl
    import lpmr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_stat.need_len) begin
                    n_state = ST_WAIT_LEN;
                end else if (i_stat.need_data) begin
                    n_state = ST_WAIT_DATA;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WAIT_LEN:  n_state = ST_DECIDE;
            ST_WAIT_DATA: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_DECIDE:    o_cmd.decide    = 1'b1;
            ST_WAIT_LEN:  o_cmd.len_take  = 1'b1;
            ST_WAIT_DATA: o_cmd.data_take = 1'b1;
        endcase
    end

    a_decide_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DECIDE |-> $past(r_state) == ST_WAIT_LEN || $past(start))
        else $error("decide entered without a command or a length read");

    a_data_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WAIT_DATA |-> $past(r_state) == ST_DECIDE)
        else $error("data wait not preceded by decide");

    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DECIDE |-> !(i_stat.need_len && i_stat.need_data))
        else $error("length and data read requested together");

endmodule

/* design/lpmr_dp.sv */
// ----------------------------------------------------------------------------
// lpmr_dp
// Datapath: per-mailbox pointers and counters, the byte ring memory and the
// result registers.
// ----------------------------------------------------------------------------
module lpmr_dp
    import lpmr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [OP_W-1:0]      i_op,
    input  logic [MB_W-1:0]      i_mailbox,
    input  logic [LEN_W-1:0]     i_msg_length,
    input  logic [LEN_W-1:0]     i_data_byte,
    output t_dp_stat             o_stat,
    output logic                 o_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [LEN_W-1:0]     o_data,
    output logic [LEN_W-1:0]     o_length_out,
    output logic                 o_last,
    output logic [CNT_OUT_W-1:0] o_msg_count,
    output logic [CNT_OUT_W-1:0] o_space
);

    // latched command
    t_op              r_op;
    logic [MB_W-1:0]  r_mb;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_byte;

    // per-mailbox state
    logic [PTR_W-1:0] r_head      [NUM_MAILBOXES];
    logic [PTR_W-1:0] r_tail      [NUM_MAILBOXES];
    logic [CNT_W-1:0] r_cnt       [NUM_MAILBOXES];
    logic [LEN_W-1:0] r_send_left [NUM_MAILBOXES];
    logic [LEN_W-1:0] r_send_len  [NUM_MAILBOXES];
    logic             r_send_busy [NUM_MAILBOXES];
    logic [LEN_W-1:0] r_recv_left [NUM_MAILBOXES];
    logic [LEN_W-1:0] r_recv_len  [NUM_MAILBOXES];
    logic             r_recv_busy [NUM_MAILBOXES];

    logic [LEN_W-1:0] mem [MEM_DEPTH];
    logic [LEN_W-1:0] r_rdata;

    // result word
    logic             r_valid;
    t_status          r_status;
    logic [LEN_W-1:0] r_data;
    logic [LEN_W-1:0] r_lout;
    logic             r_last;
    logic             r_oor;

    logic [MB_IDX_W-1:0] idx;
    logic                oor;
    logic [PTR_W-1:0]    head;
    logic [PTR_W-1:0]    tail;
    logic [CNT_W-1:0]    cnt;
    logic [CNT_W-1:0]    space;
    logic [LEN1_W-1:0]   send_off;
    logic [LEN1_W-1:0]   recv_off;

    logic [PTR_W-1:0]    n_head;
    logic [PTR_W-1:0]    n_tail;
    logic [CNT_W-1:0]    n_cnt;
    logic [LEN_W-1:0]    n_send_left;
    logic [LEN_W-1:0]    n_send_len;
    logic                n_send_busy;
    logic [LEN_W-1:0]    n_recv_left;
    logic [LEN_W-1:0]    n_recv_len;
    logic                n_recv_busy;
    logic                upd;

    logic                fin;
    t_status             n_status;
    logic [LEN_W-1:0]    n_data;
    logic [LEN_W-1:0]    n_lout;
    logic                n_last;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [LEN_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    assign idx      = MB_IDX_W'(r_mb);
    assign oor      = 32'(r_mb) >= 32'(NUM_MAILBOXES);
    assign head     = r_head[idx];
    assign tail     = r_tail[idx];
    assign cnt      = r_cnt[idx];
    assign space    = free_space(head, tail, cnt);
    assign send_off = LEN1_W'(r_send_len[idx]) - LEN1_W'(r_send_left[idx]) + LEN1_W'(1);
    assign recv_off = LEN1_W'(r_recv_len[idx]) - LEN1_W'(r_recv_left[idx]) + LEN1_W'(1);

    always_comb begin
        n_head      = head;
        n_tail      = tail;
        n_cnt       = cnt;
        n_send_left = r_send_left[idx];
        n_send_len  = r_send_len[idx];
        n_send_busy = r_send_busy[idx];
        n_recv_left = r_recv_left[idx];
        n_recv_len  = r_recv_len[idx];
        n_recv_busy = r_recv_busy[idx];
        upd         = 1'b0;
        fin         = 1'b0;
        n_status    = STAT_OK;
        n_data      = '0;
        n_lout      = '0;
        n_last      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = {idx, head};
        mem_wdata   = r_len;
        mem_re      = 1'b0;
        mem_raddr   = {idx, tail};
        o_stat      = '0;

        if (i_cmd.decide) begin
            fin = 1'b1;
            if (oor) begin
                n_status = STAT_SEQ;
            end else begin
                unique case (r_op)
                    OP_SEND_BEGIN: begin
                        if (r_send_busy[idx]) begin
                            n_status = STAT_SEQ;
                        end else if (CMP_W'(r_len) >= CMP_W'(space)) begin
                            n_status = STAT_NO_SPACE;
                        end else begin
                            mem_we = 1'b1;
                            upd    = 1'b1;
                            if (r_len == '0) begin
                                n_head = ring_wrap(head, LEN1_W'(1));
                                n_cnt  = cnt + CNT_W'(1);
                            end else begin
                                n_send_busy = 1'b1;
                                n_send_left = r_len;
                                n_send_len  = r_len;
                            end
                        end
                    end
                    OP_SEND_BYTE: begin
                        if (!r_send_busy[idx]) begin
                            n_status = STAT_SEQ;
                        end else begin
                            mem_we      = 1'b1;
                            mem_waddr   = {idx, ring_wrap(head, send_off)};
                            mem_wdata   = r_byte;
                            upd         = 1'b1;
                            n_send_left = r_send_left[idx] - LEN_W'(1);
                            if (r_send_left[idx] == LEN_W'(1)) begin
                                n_head = ring_wrap(head,
                                                   LEN1_W'(r_send_len[idx]) + LEN1_W'(1));
                                n_cnt       = cnt + CNT_W'(1);
                                n_send_busy = 1'b0;
                            end
                        end
                    end
                    OP_RECV: begin
                        if (!r_recv_busy[idx] && cnt == '0) begin
                            n_status = STAT_NO_MSG;
                        end else if (!r_recv_busy[idx]) begin
                            fin             = 1'b0;
                            o_stat.need_len = 1'b1;
                            mem_re          = 1'b1;
                        end else if (r_recv_left[idx] == '0) begin
                            // empty body: one result that closes the message
                            upd         = 1'b1;
                            n_lout      = r_recv_len[idx];
                            n_last      = 1'b1;
                            n_tail      = ring_wrap(tail,
                                                    LEN1_W'(r_recv_len[idx]) + LEN1_W'(1));
                            n_cnt       = (cnt != '0) ? cnt - CNT_W'(1) : cnt;
                            n_recv_busy = 1'b0;
                        end else begin
                            fin              = 1'b0;
                            o_stat.need_data = 1'b1;
                            mem_re           = 1'b1;
                            mem_raddr        = {idx, ring_wrap(tail, recv_off)};
                        end
                    end
                    OP_QUERY: begin
                        n_status = STAT_OK;
                    end
                endcase
            end
        end else if (i_cmd.len_take) begin
            upd         = 1'b1;
            n_recv_busy = 1'b1;
            n_recv_left = r_rdata;
            n_recv_len  = r_rdata;
        end else if (i_cmd.data_take) begin
            fin         = 1'b1;
            upd         = 1'b1;
            n_data      = r_rdata;
            n_lout      = r_recv_len[idx];
            n_recv_left = r_recv_left[idx] - LEN_W'(1);
            if (r_recv_left[idx] == LEN_W'(1)) begin
                n_last      = 1'b1;
                n_tail      = ring_wrap(tail, LEN1_W'(r_recv_len[idx]) + LEN1_W'(1));
                n_cnt       = (cnt != '0) ? cnt - CNT_W'(1) : cnt;
                n_recv_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_mb   <= i_mailbox;
            r_len  <= i_msg_length;
            r_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MAILBOXES; i++) begin
                r_head[i]      <= '0;
                r_tail[i]      <= '0;
                r_cnt[i]       <= '0;
                r_send_left[i] <= '0;
                r_send_len[i]  <= '0;
                r_send_busy[i] <= 1'b0;
                r_recv_left[i] <= '0;
                r_recv_len[i]  <= '0;
                r_recv_busy[i] <= 1'b0;
            end
        end else if (upd) begin
            r_head[idx]      <= n_head;
            r_tail[idx]      <= n_tail;
            r_cnt[idx]       <= n_cnt;
            r_send_left[idx] <= n_send_left;
            r_send_len[idx]  <= n_send_len;
            r_send_busy[idx] <= n_send_busy;
            r_recv_left[idx] <= n_recv_left;
            r_recv_len[idx]  <= n_recv_len;
            r_recv_busy[idx] <= n_recv_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_lout   <= n_lout;
            r_last   <= n_last;
            r_oor    <= oor;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_data       = r_data;
    assign o_length_out = r_lout;
    assign o_last       = r_last;
    assign o_msg_count  = r_oor ? '0 : CNT_OUT_W'(cnt);
    assign o_space      = r_oor ? '0 : CNT_OUT_W'(space);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |-> r_status == STAT_OK)
        else $error("last flag on a failed word");

endmodule

/* design/length_prefixed_mailbox_ring.sv */
// ----------------------------------------------------------------------------
// length_prefixed_mailbox_ring
// Eight byte-ring mailboxes holding length-prefixed messages.
// ----------------------------------------------------------------------------
// Usage: drive i_op, i_mailbox, i_msg_length and i_data_byte and raise start;
// the word is taken on a rising edge with start high and busy low. Exactly
// one result word follows, shown for a single cycle with o_valid high; the
// receiver must take it then, as nothing holds it.
// Steps, from the accepting edge to the result: send begin, body byte and
// status query take one decision pass; a receive mid-message adds the
// registered ring read of the body byte; the first byte of a message takes
// a decision pass, the length byte read, a second decision pass and then the
// body byte read (an empty body ends at the second decision pass). busy
// drops in the o_valid cycle, so the next word may be offered there.
// o_msg_count and o_space reflect the mailbox after the item. Reset clears
// all pointers, counts and open send/receive state; the ring memory itself
// is not cleared and is only read where written.
// ----------------------------------------------------------------------------
module length_prefixed_mailbox_ring
    import lpmr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_op,
    input  logic [MB_W-1:0]      i_mailbox,
    input  logic [LEN_W-1:0]     i_msg_length,
    input  logic [LEN_W-1:0]     i_data_byte,
    output logic                 o_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [LEN_W-1:0]     o_data,
    output logic [LEN_W-1:0]     o_length_out,
    output logic                 o_last,
    output logic [CNT_OUT_W-1:0] o_msg_count,
    output logic [CNT_OUT_W-1:0] o_space
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lpmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    lpmr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_mailbox    (i_mailbox),
        .i_msg_length (i_msg_length),
        .i_data_byte  (i_data_byte),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_length_out (o_length_out),
        .o_last       (o_last),
        .o_msg_count  (o_msg_count),
        .o_space      (o_space)
    );

endmodule
